// ===== hdl/bezier_curve_flattener_assert.svh =====
// assertion macros used by the checker file
`ifndef BEZIER_CURVE_FLATTENER_ASSERT_SVH
`define BEZIER_CURVE_FLATTENER_ASSERT_SVH

// condition implies consequence in the same cycle
`define BCF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition implies consequence in the next cycle
`define BCF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/bcf_pkg.sv =====
// shared types, constants and the evaluation program of the curve flattener
package bcf_pkg;

    localparam int COORD_BITS   = 24;
    localparam int MAX_SEGMENTS = 64;
    localparam int CNT_BITS     = 7;
    localparam int T_BITS       = 16;
    localparam int DIV_BITS     = T_BITS + 1;
    localparam int PC_BITS      = 4;
    localparam int DCNT_BITS    = 5;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS    = DIFF_BITS + T_BITS + 1;
    localparam int IN_DATA_W    = 232;
    localparam int OUT_DATA_W   = 128;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD,
        ST_EVAL,
        ST_EMIT,
        ST_FINAL
    } t_state;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_PUSH,
        OP_DROP,
        OP_DONE
    } t_op;

    typedef struct packed {
        logic capture;
        logic div_step;
        logic load;
        t_op  op;
        logic save_prev;
        logic t_step;
        logic out_load;
        logic out_final;
    } t_cmd;

    typedef struct packed {
        logic                cubic;
        logic                out_free;
        logic [CNT_BITS-1:0] n;
    } t_status;

    // de casteljau program over a four entry shift line
    function automatic t_op op_at(input logic cubic, input logic [PC_BITS-1:0] pc);
        t_op r;
        if (cubic) begin
            unique case (pc)
                4'd0, 4'd2, 4'd4, 4'd7, 4'd9, 4'd13: r = OP_MUL;
                4'd1, 4'd3, 4'd5, 4'd8, 4'd10, 4'd14: r = OP_PUSH;
                4'd6, 4'd11, 4'd12:                 r = OP_DROP;
                default:                            r = OP_DONE;
            endcase
        end else begin
            unique case (pc)
                4'd0, 4'd2, 4'd6: r = OP_MUL;
                4'd1, 4'd3, 4'd7: r = OP_PUSH;
                4'd4, 4'd5:       r = OP_DROP;
                default:          r = OP_DONE;
            endcase
        end
        return r;
    endfunction

endpackage

// ===== hdl/bcf_ctrl.sv =====
// sequencer: divider steps, evaluation program, segment emission
module bcf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  bcf_pkg::t_status i_status,
    output bcf_pkg::t_cmd    o_cmd
);

    bcf_pkg::t_state                     r_state, n_state;
    logic [bcf_pkg::PC_BITS-1:0]         r_pc, n_pc;
    logic [bcf_pkg::CNT_BITS-1:0]        r_i, n_i;
    logic [bcf_pkg::DCNT_BITS-1:0]       r_dcnt, n_dcnt;
    bcf_pkg::t_op                        op;
    logic [bcf_pkg::CNT_BITS:0]          i_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcf_pkg::ST_IDLE;
            r_pc    <= '0;
            r_i     <= '0;
            r_dcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_i     <= n_i;
            r_dcnt  <= n_dcnt;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_i         = r_i;
        n_dcnt      = r_dcnt;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        o_cmd.op    = bcf_pkg::OP_DONE;
        op          = bcf_pkg::op_at(i_status.cubic, r_pc);
        i_next      = {1'b0, r_i} + 1'b1;
        unique case (r_state)
            bcf_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_dcnt        = '0;
                    n_i           = '0;
                    n_state       = bcf_pkg::ST_DIV;
                end
            end
            bcf_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_dcnt         = r_dcnt + 1'b1;
                if (r_dcnt == bcf_pkg::DCNT_BITS'(bcf_pkg::DIV_BITS - 1)) begin
                    n_state = bcf_pkg::ST_LOAD;
                end
            end
            bcf_pkg::ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_pc       = '0;
                n_state    = bcf_pkg::ST_EVAL;
            end
            bcf_pkg::ST_EVAL: begin
                o_cmd.op = op;
                if (op == bcf_pkg::OP_DONE) begin
                    if (r_i == '0) begin
                        o_cmd.save_prev = 1'b1;
                        o_cmd.t_step    = 1'b1;
                        n_i             = i_next[bcf_pkg::CNT_BITS-1:0];
                        n_state = (i_next == {1'b0, i_status.n}) ? bcf_pkg::ST_FINAL
                                                                 : bcf_pkg::ST_LOAD;
                    end else begin
                        n_state = bcf_pkg::ST_EMIT;
                    end
                end else begin
                    n_pc = r_pc + 1'b1;
                end
            end
            bcf_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.save_prev = 1'b1;
                    o_cmd.t_step    = 1'b1;
                    n_i             = i_next[bcf_pkg::CNT_BITS-1:0];
                    n_state = (i_next == {1'b0, i_status.n}) ? bcf_pkg::ST_FINAL
                                                             : bcf_pkg::ST_LOAD;
                end
            end
            bcf_pkg::ST_FINAL: begin
                if (i_status.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_final = 1'b1;
                    n_state         = bcf_pkg::ST_IDLE;
                end
            end
            default: n_state = bcf_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== hdl/bcf_dpath.sv =====
// datapath: point store, step divider, parameter accumulator, lerp unit, output register
module bcf_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [bcf_pkg::IN_DATA_W-1:0]  i_req_data,
    input  logic                           i_req_cubic,
    input  bcf_pkg::t_cmd                  i_cmd,
    output bcf_pkg::t_status               o_status,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [bcf_pkg::OUT_DATA_W-1:0] o_out_data,
    output logic                           o_out_last
);

    localparam int CB = bcf_pkg::COORD_BITS;
    localparam int NB = bcf_pkg::CNT_BITS;
    localparam int SUM_BITS = bcf_pkg::PROD_BITS - bcf_pkg::T_BITS + 1;
    localparam logic signed [SUM_BITS-1:0] V_MAX = SUM_BITS'((2 ** (CB - 1)) - 1);
    localparam logic signed [SUM_BITS-1:0] V_MIN = SUM_BITS'(-(2 ** (CB - 1)));

    bcf_pkg::t_coord               r_px [4];
    bcf_pkg::t_coord               r_py [4];
    bcf_pkg::t_coord               r_wx [4];
    bcf_pkg::t_coord               r_wy [4];
    bcf_pkg::t_coord               r_prev_x, r_prev_y;
    logic                          r_cubic;
    logic [31:0]                   r_rgba;
    logic [NB-1:0]                 r_n;
    logic [NB-1:0]                 r_rem, r_rr;
    logic [bcf_pkg::DIV_BITS-1:0]  r_dvd, r_quo, r_t;
    logic signed [bcf_pkg::PROD_BITS-1:0] r_prod_x, r_prod_y;
    logic                          r_out_valid;
    logic                          r_out_last;
    bcf_pkg::t_coord               r_oax, r_oay, r_obx, r_oby;
    logic [31:0]                   r_orgba;

    logic [NB-1:0]                 seg_in, n_sat;
    logic [NB:0]                   rem_sh, rr_sum;
    logic signed [bcf_pkg::PROD_BITS-1:0] prod_x, prod_y;
    bcf_pkg::t_coord               res_x, res_y;
    logic                          out_free;

    function automatic logic signed [bcf_pkg::PROD_BITS-1:0] mul_diff(
        input bcf_pkg::t_coord a, input bcf_pkg::t_coord b,
        input logic [bcf_pkg::T_BITS-1:0] t);
        logic signed [bcf_pkg::DIFF_BITS-1:0] d;
        logic signed [bcf_pkg::T_BITS:0]      ts;
        d  = bcf_pkg::DIFF_BITS'(b) - bcf_pkg::DIFF_BITS'(a);
        ts = $signed({1'b0, t});
        return bcf_pkg::PROD_BITS'(d * ts);
    endfunction

    function automatic bcf_pkg::t_coord round_add(
        input bcf_pkg::t_coord a, input logic signed [bcf_pkg::PROD_BITS-1:0] p);
        logic signed [bcf_pkg::PROD_BITS-1:0] s;
        logic signed [SUM_BITS-1:0]           v;
        s = p + bcf_pkg::PROD_BITS'(32768);
        v = SUM_BITS'(s >>> bcf_pkg::T_BITS) + SUM_BITS'(a);
        if (v > V_MAX) begin
            return {1'b0, {(CB-1){1'b1}}};
        end else if (v < V_MIN) begin
            return {1'b1, {(CB-1){1'b0}}};
        end
        return v[CB-1:0];
    endfunction

    assign seg_in   = i_req_data[8*CB+32 +: NB];
    assign n_sat    = (seg_in == '0) ? NB'(1)
                    : (seg_in > NB'(bcf_pkg::MAX_SEGMENTS)) ? NB'(bcf_pkg::MAX_SEGMENTS)
                    : seg_in;
    assign rem_sh   = {r_rem, r_dvd[bcf_pkg::DIV_BITS-1]};
    assign rr_sum   = {1'b0, r_rr} + {1'b0, r_rem};
    assign prod_x   = mul_diff(r_wx[0], r_wx[1], r_t[bcf_pkg::T_BITS-1:0]);
    assign prod_y   = mul_diff(r_wy[0], r_wy[1], r_t[bcf_pkg::T_BITS-1:0]);
    assign res_x    = round_add(r_wx[0], r_prod_x);
    assign res_y    = round_add(r_wy[0], r_prod_y);
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_px[0]  <= i_req_data[0 +: CB];
            r_py[0]  <= i_req_data[CB +: CB];
            r_px[1]  <= i_req_data[4*CB +: CB];
            r_py[1]  <= i_req_data[5*CB +: CB];
            r_px[2]  <= i_req_data[6*CB +: CB];
            r_py[2]  <= i_req_data[7*CB +: CB];
            r_px[3]  <= i_req_data[2*CB +: CB];
            r_py[3]  <= i_req_data[3*CB +: CB];
            r_cubic  <= i_req_cubic;
            r_rgba   <= i_req_data[8*CB +: 32];
            r_n      <= n_sat;
            r_rem    <= '0;
            r_dvd    <= {1'b1, {bcf_pkg::T_BITS{1'b0}}};
            r_quo    <= '0;
            r_t      <= '0;
            r_rr     <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[bcf_pkg::DIV_BITS-2:0], 1'b0};
            if (rem_sh >= {1'b0, r_n}) begin
                r_rem <= NB'(rem_sh - {1'b0, r_n});
                r_quo <= {r_quo[bcf_pkg::DIV_BITS-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[NB-1:0];
                r_quo <= {r_quo[bcf_pkg::DIV_BITS-2:0], 1'b0};
            end
        end
        if (i_cmd.t_step) begin
            if (rr_sum >= {1'b0, r_n}) begin
                r_rr <= NB'(rr_sum - {1'b0, r_n});
                r_t  <= r_t + r_quo + 1'b1;
            end else begin
                r_rr <= rr_sum[NB-1:0];
                r_t  <= r_t + r_quo;
            end
        end
        if (i_cmd.load) begin
            r_wx[0] <= r_px[0];
            r_wy[0] <= r_py[0];
            r_wx[1] <= r_px[1];
            r_wy[1] <= r_py[1];
            r_wx[2] <= r_cubic ? r_px[2] : r_px[3];
            r_wy[2] <= r_cubic ? r_py[2] : r_py[3];
            r_wx[3] <= r_px[3];
            r_wy[3] <= r_py[3];
        end
        case (i_cmd.op)
            bcf_pkg::OP_MUL: begin
                r_prod_x <= prod_x;
                r_prod_y <= prod_y;
            end
            bcf_pkg::OP_PUSH, bcf_pkg::OP_DROP: begin
                for (int k = 0; k < 3; k++) begin
                    r_wx[k] <= r_wx[k+1];
                    r_wy[k] <= r_wy[k+1];
                end
                if (i_cmd.op == bcf_pkg::OP_PUSH) begin
                    r_wx[3] <= res_x;
                    r_wy[3] <= res_y;
                end
            end
            default: ;
        endcase
        if (i_cmd.out_load) begin
            r_oax   <= r_prev_x;
            r_oay   <= r_prev_y;
            r_obx   <= i_cmd.out_final ? r_px[3] : r_wx[3];
            r_oby   <= i_cmd.out_final ? r_py[3] : r_wy[3];
            r_orgba <= r_rgba;
        end
        if (i_cmd.save_prev) begin
            r_prev_x <= r_wx[3];
            r_prev_y <= r_wy[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
            r_out_last  <= i_cmd.out_final;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.cubic    = r_cubic;
    assign o_status.out_free = out_free;
    assign o_status.n        = r_n;
    assign o_out_valid       = r_out_valid;
    assign o_out_last        = r_out_last;
    assign o_out_data        = {r_orgba, r_oby, r_obx, r_oay, r_oax};

endmodule

// ===== hdl/bezier_curve_flattener.sv =====
// Bezier curve flattener top level
// Takes one quadratic or cubic curve request and emits n line segments (n = 1..64) at uniform
// parameter steps t = i/n, the final endpoint being the curve end point exactly. One shared pair
// of multipliers evaluates each point by repeated interpolation, after a serial divider finds
// the parameter step.
// A new request is taken once the previous one has handed its last segment to the output
// register.
module bezier_curve_flattener (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // start_x, start_y, end_x, end_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, rgba, segments
    input  logic [bcf_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // curve kind: 1 selects cubic, 0 quadratic
    input  logic                           i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // seg_a_x, seg_a_y, seg_b_x, seg_b_y, seg_rgba
    output logic [bcf_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                           o_m_axis_tlast
);

    bcf_pkg::t_cmd    cmd;
    bcf_pkg::t_status status;

    bcf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bcf_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_data  (i_s_axis_tdata),
        .i_req_cubic (i_s_axis_tuser),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule

// ===== hdl/bcf_checker.sv =====
// port level checks of the curve flattener and their binding
`include "bezier_curve_flattener_assert.svh"

module bcf_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [bcf_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                           o_m_axis_tlast
);

    `BCF_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))
    `BCF_ASSERT_NEXT(a_busy_after_request, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    `BCF_ASSERT_SAME(a_busy_mid_curve, o_m_axis_tvalid && !o_m_axis_tlast, !o_s_axis_tready)

endmodule

bind bezier_curve_flattener bcf_checker u_bcf_checker (.*);
